### src/wnpm_pkg.sv
// Shared types, constants and weights for the weighted nearest patch match block.
package wnpm_pkg;

  localparam int unsigned PATCH_BYTES = 11;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PATCH_W     = PATCH_BYTES * BYTE_W;
  localparam int unsigned TERM_W      = 10;
  localparam int unsigned HALF_W      = 12;
  localparam int unsigned DIST_W      = 13;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned LOW_TERMS   = 6;

  // Command codes carried in the input tuser bit
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Per-byte weights, lowest byte first
  localparam logic [1:0] BYTE_WEIGHT [PATCH_BYTES] = '{
    2'd2, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd1, 2'd1
  };

  typedef logic [PATCH_W-1:0] patch_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dist_sum;
  } dist_res_t;

endpackage

### src/wnpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wnpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word and register one read word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### src/wnpm_dist.sv
// Pipelined weighted absolute-difference distance unit, one entry per cycle.
module wnpm_dist (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  wnpm_pkg::patch_t    stored_i,
  input  wnpm_pkg::patch_t    probe_i,
  output wnpm_pkg::dist_res_t res_o
);

  localparam int unsigned NB = wnpm_pkg::PATCH_BYTES;
  localparam int unsigned BW = wnpm_pkg::BYTE_W;
  localparam int unsigned TW = wnpm_pkg::TERM_W;
  localparam int unsigned HW = wnpm_pkg::HALF_W;
  localparam int unsigned DW = wnpm_pkg::DIST_W;
  localparam int unsigned LT = wnpm_pkg::LOW_TERMS;

  logic [TW-1:0] term_d [NB];
  logic [TW-1:0] term_q [NB];
  logic [HW-1:0] lo_d, hi_d, lo_q, hi_q;
  logic [DW-1:0] dist_q;
  logic          v1_q, v2_q, v3_q;

  // Form weighted absolute byte differences
  always_comb begin
    logic [BW-1:0] a, b, diff;
    for (int k = 0; k < NB; k++) begin
      a = stored_i[k*BW +: BW];
      b = probe_i[k*BW +: BW];
      diff = (a >= b) ? (a - b) : (b - a);
      term_d[k] = TW'(diff) * TW'(wnpm_pkg::BYTE_WEIGHT[k]);
    end
  end

  // Sum the two halves of the terms
  always_comb begin
    lo_d = '0;
    hi_d = '0;
    for (int k = 0; k < LT; k++) begin
      lo_d = lo_d + HW'(term_q[k]);
    end
    for (int k = LT; k < NB; k++) begin
      hi_d = hi_d + HW'(term_q[k]);
    end
  end

  // Register the stage data
  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    dist_q <= DW'(lo_q) + DW'(hi_q);
  end

  // Advance the stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign res_o.valid    = v3_q;
  assign res_o.dist_sum = dist_q;

endmodule

### src/weighted_nearest_patch_match.sv
// Top level of the weighted nearest patch match: patch table, scan sequencer and output register.
//
// Input stream (s_axis): tuser selects the command, load (0) or query (1); tdata carries
// the eleven patch bytes. A load appends the patch to the table and gives no result; a
// load into a full table is dropped. A query scans every stored entry, one entry per
// cycle read from the single read port of the patch memory, through a three-stage
// distance unit, and gives one result on the output stream (m_axis): tuser is the
// found flag, tdata the index of the first entry with the least weighted distance and
// that distance. A query on an empty table answers not found with index and distance
// zero.
// The input is not ready while a query scans. The result sits in an output register:
// while the receiver stalls, further loads and a new query are still accepted, and a
// finished query waits until the output register is free.
// Reset empties the table (entry count zero) and clears all control state; memory
// contents are left as they are and are never read before being written.
module weighted_nearest_patch_match #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command
  input  logic        s_axis_tuser,
  // mod_character, car_character, mod_level, car_level, mod_attack_decay,
  // car_attack_decay, mod_sustain_release, car_sustain_release,
  // feedback_connection, mod_waveform, car_waveform (8 bits each)
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found
  output logic        m_axis_tuser,
  // best_index [9:0], best_distance [22:10], zero [23]
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = wnpm_pkg::INDEX_W;
  localparam int unsigned DW = wnpm_pkg::DIST_W;
  localparam int unsigned XW = (AW > IW) ? AW : IW;

  wnpm_pkg::state_e    state_q, state_d;
  wnpm_pkg::patch_t    probe_q;
  wnpm_pkg::patch_t    rd_data;
  wnpm_pkg::dist_res_t res;

  logic [CW-1:0] count_q;
  logic [CW-1:0] rd_cnt_q;
  logic [CW-1:0] cmp_idx_q;
  logic          rd_valid_q;
  logic [AW-1:0] best_idx_q;
  logic [DW-1:0] best_d_q;
  logic          found_q;
  logic          m_valid_q;
  logic          m_found_q;
  logic [IW-1:0] m_idx_q;
  logic [DW-1:0] m_dist_q;
  logic [XW-1:0] best_idx_ext;

  logic in_acc, is_query, is_load, not_full, wr_en, issue_en, scan_last, out_load;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign is_query  = (s_axis_tuser == wnpm_pkg::CMD_QUERY);
  assign is_load   = (s_axis_tuser == wnpm_pkg::CMD_LOAD);
  assign not_full  = (count_q < CW'(TABLE_DEPTH));
  assign wr_en     = in_acc && is_load && not_full;
  assign scan_last = res.valid && (cmp_idx_q == (count_q - CW'(1)));

  // Decode sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue_en      = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      wnpm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      wnpm_pkg::ST_SCAN: begin
        issue_en = (rd_cnt_q < count_q);
      end
      wnpm_pkg::ST_DONE: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Pick the next sequencer state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wnpm_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = (count_q == '0) ? wnpm_pkg::ST_DONE : wnpm_pkg::ST_SCAN;
        end
      end
      wnpm_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = wnpm_pkg::ST_DONE;
        end
      end
      wnpm_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = wnpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wnpm_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold the patch table
  wnpm_ram #(
    .WIDTH (wnpm_pkg::PATCH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (issue_en),
    .raddr_i (rd_cnt_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Score each stored entry against the probe
  wnpm_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rd_valid_q),
    .stored_i (rd_data),
    .probe_i  (probe_q),
    .res_o    (res)
  );

  // Latch the probe of a query
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      probe_q <= s_axis_tdata;
    end
  end

  // Track the best entry seen so far
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      best_idx_q <= '0;
      best_d_q   <= '0;
    end else if (res.valid && ((cmp_idx_q == '0) || (res.dist_sum < best_d_q))) begin
      best_idx_q <= cmp_idx_q[AW-1:0];
      best_d_q   <= res.dist_sum;
    end
  end

  // Load the output payload
  assign best_idx_ext = XW'(best_idx_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_found_q <= found_q;
      m_idx_q   <= best_idx_ext[IW-1:0];
      m_dist_q  <= best_d_q;
    end
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wnpm_pkg::ST_IDLE;
      count_q    <= '0;
      rd_cnt_q   <= '0;
      cmp_idx_q  <= '0;
      rd_valid_q <= 1'b0;
      found_q    <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue_en;
      if (wr_en) begin
        count_q <= count_q + CW'(1);
      end
      if (in_acc && is_query) begin
        rd_cnt_q  <= '0;
        cmp_idx_q <= '0;
        found_q   <= (count_q != '0);
      end else begin
        if (issue_en) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
        if (res.valid) begin
          cmp_idx_q <= cmp_idx_q + CW'(1);
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = {1'b0, m_dist_q, m_idx_q};

  // The table never holds more entries than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Reads never run past the stored entries
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_cnt_q <= count_q)
    else $error("read pointer beyond entry count");

  // Distance results only arrive during a scan
  a_res_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (state_q == wnpm_pkg::ST_SCAN))
    else $error("distance result outside a scan");

  // A not-found answer carries zero index and distance
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_found_q) |-> ((m_idx_q == '0) && (m_dist_q == '0)))
    else $error("not-found result with nonzero payload");

  // A query only finishes after every stored entry was compared
  a_scan_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == wnpm_pkg::ST_SCAN) && (state_d == wnpm_pkg::ST_DONE)) |-> (rd_cnt_q == count_q))
    else $error("scan ended before all entries were read");

endmodule
